// ===== hw/rtl/fat_chain_extent_builder_unit_assert.svh =====
// Assertion macros shared by the extent builder RTL.
// Every check is sampled on the rising edge of clock and is off while reset is high.
`ifndef FAT_CHAIN_EXTENT_BUILDER_UNIT_ASSERT_SVH
`define FAT_CHAIN_EXTENT_BUILDER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define FCEB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define FCEB_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define FCEB_ASSERT(label, prop, msg)
`define FCEB_NEVER(label, cond, msg)
`endif

`endif

// ===== hw/rtl/fceb_pkg.sv =====
`default_nettype none

package fceb_pkg;

   localparam int CLUSTER_W     = 28;
   localparam int SECTOR_W      = 32;
   localparam int LENGTH_W      = 40;
   localparam int SPC_W         = 8;
   localparam int FAT_TYPE_W    = 2;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 32;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Register indexes on the configuration channel.
   localparam logic [CSR_INDEX_W-1:0] CSR_FAT_TYPE          = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLUSTER_SECTORS   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_DATA_SECTOR = 2'd2;

   localparam logic [FAT_TYPE_W-1:0]  FAT_TYPE_RESET = 2'd2;
   localparam logic [SPC_W-1:0]       SPC_RESET      = 8'd1;

   localparam logic [CLUSTER_W-1:0] CLUSTER_BASE = 28'd2;

   typedef enum logic [1:0] {
      FAT_12 = 2'd0,
      FAT_16 = 2'd1,
      FAT_32 = 2'd2
   } fat_kind_type;

   typedef enum logic [1:0] {
      CAUSE_NONE      = 2'd0,
      CAUSE_END_MARK  = 2'd1,
      CAUSE_BELOW_TWO = 2'd2,
      CAUSE_BAD       = 2'd3
   } cause_type;

   // One classified cluster, as the front hands it to the back.
   typedef struct packed {
      logic [SECTOR_W-1:0] sector;
      cause_type           cause;
      logic                new_chain;
   } item_type;

endpackage

`default_nettype wire

// ===== hw/rtl/fceb_intf.sv =====
`default_nettype none

interface fceb_req_if import fceb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CLUSTER_W-1:0] cluster;
   logic                 new_chain;

   modport source (output valid, output cluster, output new_chain, input ready);
   modport sink   (input valid, input cluster, input new_chain, output ready);
endinterface

interface fceb_rsp_if import fceb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SECTOR_W-1:0] extent_start;
   logic [LENGTH_W-1:0] extent_sectors;
   logic                extent_valid;
   logic                chain_end;
   cause_type           end_cause;

   modport source (output valid, output extent_start, output extent_sectors,
                   output extent_valid, output chain_end, output end_cause, input ready);
   modport sink   (input valid, input extent_start, input extent_sectors,
                   input extent_valid, input chain_end, input end_cause, output ready);
endinterface

interface fceb_csr_if import fceb_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fceb_front.sv =====
`default_nettype none

module fceb_front import fceb_pkg::*; (
   fceb_req_if.sink              req_if,
   input  wire logic [FAT_TYPE_W-1:0] fat_type,
   input  wire logic [SPC_W-1:0]      cluster_sectors,
   input  wire logic [SECTOR_W-1:0]   first_data_sector,
   output      logic                  push_valid,
   input  wire logic                  push_ready,
   output      item_type              push_item
);

   logic                          is_end;
   logic                          is_bad;
   logic [CLUSTER_W-1:0]          offset;
   logic [CLUSTER_W+SPC_W-1:0]    product;
   cause_type                     cause;

   assign push_valid   = req_if.valid;
   assign req_if.ready = push_ready;

   // Marker thresholds per FAT flavor; an undefined type ends every chain.
   always_comb begin
      unique case (fat_kind_type'(fat_type))
         FAT_12: begin
            is_end = req_if.cluster >= 28'h0000FF8;
            is_bad = req_if.cluster == 28'h0000FF7;
         end
         FAT_16: begin
            is_end = req_if.cluster >= 28'h000FFF8;
            is_bad = req_if.cluster == 28'h000FFF7;
         end
         FAT_32: begin
            is_end = req_if.cluster >= 28'hFFFFFF8;
            is_bad = req_if.cluster == 28'hFFFFFF7;
         end
         default: begin
            is_end = 1'b1;
            is_bad = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (is_end) begin
         cause = CAUSE_END_MARK;
      end else if (req_if.cluster < CLUSTER_BASE) begin
         cause = CAUSE_BELOW_TWO;
      end else if (is_bad) begin
         cause = CAUSE_BAD;
      end else begin
         cause = CAUSE_NONE;
      end
   end

   // The sector only matters when the cluster is at least two, so a wrapped offset below that does no harm.
   assign offset  = req_if.cluster - CLUSTER_BASE;
   assign product = {{SPC_W{1'b0}}, offset} * {{CLUSTER_W{1'b0}}, cluster_sectors};

   always_comb begin
      push_item.sector    = first_data_sector + product[SECTOR_W-1:0];
      push_item.cause     = cause;
      push_item.new_chain = req_if.new_chain;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/fceb_queue.sv =====
`default_nettype none

module fceb_queue import fceb_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   output      logic     push_ready,
   input  wire item_type push_item,
   output      logic     pop_valid,
   input  wire logic     pop_ready,
   output      item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   item_type          entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = count_ff != FULL_CNT;
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/fceb_back.sv =====
`default_nettype none

module fceb_back import fceb_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             pop_valid,
   output      logic             pop_ready,
   input  wire item_type         pop_item,
   input  wire logic [SPC_W-1:0] cluster_sectors,
   fceb_rsp_if.source            rsp_if
);

   logic [SECTOR_W-1:0] run_start_ff, run_start_in;
   logic [LENGTH_W-1:0] run_len_ff, run_len_in;
   logic                done_ff, done_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SECTOR_W-1:0] rsp_start_ff, rsp_start_in;
   logic [LENGTH_W-1:0] rsp_len_ff, rsp_len_in;
   logic                rsp_ext_ff, rsp_ext_in;
   logic                rsp_end_ff, rsp_end_in;
   cause_type           rsp_cause_ff, rsp_cause_in;

   logic [SECTOR_W-1:0] cur_start;
   logic [LENGTH_W-1:0] cur_len;
   logic                cur_done;
   logic [LENGTH_W:0]   run_next_sector;
   logic [LENGTH_W:0]   grown_len;
   logic                contiguous;
   logic                emit;
   logic                do_pop;

   assign pop_ready = !rsp_valid_ff || rsp_if.ready;
   assign do_pop    = pop_valid && pop_ready;

   // A new chain flag clears the run before the cluster is looked at.
   assign cur_start = pop_item.new_chain ? '0 : run_start_ff;
   assign cur_len   = pop_item.new_chain ? '0 : run_len_ff;
   assign cur_done  = pop_item.new_chain ? 1'b0 : done_ff;

   assign run_next_sector = {1'b0, (LENGTH_W)'(cur_start)} + {1'b0, cur_len};
   assign contiguous      = run_next_sector == (LENGTH_W + 1)'(pop_item.sector);
   assign grown_len       = {1'b0, cur_len} + (LENGTH_W + 1)'(cluster_sectors);

   always_comb begin
      run_start_in = run_start_ff;
      run_len_in   = run_len_ff;
      done_in      = done_ff;
      emit         = 1'b0;
      rsp_start_in = rsp_start_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_ext_in   = rsp_ext_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_cause_in = rsp_cause_ff;
      if (do_pop) begin
         run_start_in = cur_start;
         run_len_in   = cur_len;
         done_in      = cur_done;
         if (cur_done) begin
            // Idle between chains: the item is dropped.
         end else if (pop_item.cause != CAUSE_NONE) begin
            emit         = 1'b1;
            rsp_start_in = (cur_len != '0) ? cur_start : '0;
            rsp_len_in   = cur_len;
            rsp_ext_in   = cur_len != '0;
            rsp_end_in   = 1'b1;
            rsp_cause_in = pop_item.cause;
            run_start_in = '0;
            run_len_in   = '0;
            done_in      = 1'b1;
         end else if (contiguous) begin
            run_len_in = grown_len[LENGTH_W] ? '1 : grown_len[LENGTH_W-1:0];
         end else begin
            emit         = cur_len != '0;
            rsp_start_in = cur_start;
            rsp_len_in   = cur_len;
            rsp_ext_in   = 1'b1;
            rsp_end_in   = 1'b0;
            rsp_cause_in = CAUSE_NONE;
            run_start_in = pop_item.sector;
            run_len_in   = (LENGTH_W)'(cluster_sectors);
         end
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_start_ff <= '0;
         run_len_ff   <= '0;
         done_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_start_ff <= run_start_in;
         run_len_ff   <= run_len_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_start_ff <= rsp_start_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_ext_ff   <= rsp_ext_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_cause_ff <= rsp_cause_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.extent_start   = rsp_start_ff;
   assign rsp_if.extent_sectors = rsp_len_ff;
   assign rsp_if.extent_valid   = rsp_ext_ff;
   assign rsp_if.chain_end      = rsp_end_ff;
   assign rsp_if.end_cause      = rsp_cause_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/fat_chain_extent_builder_unit.sv =====
// FAT chain to extent builder. Feed the clusters of one chain in order, flagging the
// first with new_chain; each cluster maps to sector first_data_sector + (cluster - 2)
// times the sectors per cluster setting, adjacent clusters merge into one run, and every
// break in the sector sequence produces one extent transfer on the response channel. An
// end marker, a cluster below two or a bad marker closes the chain with a final transfer
// that has chain_end set and carries the pending extent, or no extent if none is pending;
// later clusters are dropped until the next new_chain. The block takes one cluster per
// clock while the queue has room: the front stage classifies the cluster and forms its
// sector (one 28 x 8 multiply and a 32-bit add) and writes it into a short queue, and the
// back stage folds one queued cluster per clock, while the response is not stalled, into
// the run with a 41-bit add and compare. A result passes the queue entry and then the
// response register before it transfers. A stalled response holds the back stage, the
// queue (two entries by default) then fills and the request side stalls until the
// response moves. The configuration registers are always ready and must be written only
// while no cluster is in flight.
`default_nettype none
`include "fat_chain_extent_builder_unit_assert.svh"

module fat_chain_extent_builder_unit import fceb_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   fceb_req_if.sink  req_if,
   fceb_rsp_if.source rsp_if,
   fceb_csr_if.sink  csr_if
);

   logic [FAT_TYPE_W-1:0] fat_type_ff;
   logic [SPC_W-1:0]      spc_ff;
   logic [SECTOR_W-1:0]   fds_ff;

   logic     push_valid;
   logic     push_ready;
   item_type push_item;
   logic     pop_valid;
   logic     pop_ready;
   item_type pop_item;

   // Configuration writes are registered directly, so the channel never stalls.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fat_type_ff <= FAT_TYPE_RESET;
         spc_ff      <= SPC_RESET;
         fds_ff      <= '0;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_FAT_TYPE:          fat_type_ff <= csr_if.data[FAT_TYPE_W-1:0];
            CSR_CLUSTER_SECTORS:   spc_ff      <= csr_if.data[SPC_W-1:0];
            CSR_FIRST_DATA_SECTOR: fds_ff      <= csr_if.data[SECTOR_W-1:0];
            default: begin
               // Writes to an unmapped index are dropped.
            end
         endcase
      end
   end

   // The front classifies each accepted cluster and computes its sector.
   fceb_front u_front (
      .req_if            (req_if),
      .fat_type          (fat_type_ff),
      .cluster_sectors   (spc_ff),
      .first_data_sector (fds_ff),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_item         (push_item)
   );

   // The queue lets the request side keep moving while a result waits on the response side.
   fceb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // The back owns the pending run and the response register.
   fceb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_item        (pop_item),
      .cluster_sectors (spc_ff),
      .rsp_if          (rsp_if)
   );

   // A result without chain_end is always a real extent.
   `FCEB_ASSERT(a_mid_chain_has_extent, rsp_if.valid && !rsp_if.chain_end |-> rsp_if.extent_valid, "mid-chain result without extent")
   // An end cause is reported exactly on the closing transfer.
   `FCEB_NEVER(a_cause_matches_end, rsp_if.valid && (rsp_if.chain_end != (rsp_if.end_cause != CAUSE_NONE)), "end cause and chain end disagree")
   // A carried extent always covers at least one sector.
   `FCEB_NEVER(a_extent_not_empty, rsp_if.valid && rsp_if.extent_valid && (rsp_if.extent_sectors == '0), "extent with zero length")
   // A cluster that enters a full queue would be lost.
   `FCEB_NEVER(a_no_push_when_full, req_if.valid && req_if.ready && !push_ready, "request accepted while queue is full")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
module tb;
   import fceb_pkg::*;

   // The block has no name for the fourth fat_type code. It is used here to
   // check that every cluster then counts as an end marker.
   localparam logic [FAT_TYPE_W-1:0] FAT_UNDEFINED = 2'd3;

   // A cluster can sit in the block's short queue without producing a result.
   // Each result passes the queue and the response register, so this many idle
   // clocks after the last result leave the block empty before a register write.
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_LIMIT  = 5000;

   // The three kinds of normal cluster ranges, end markers and bad markers.
   localparam logic [CLUSTER_W-1:0] TOP_12 = 28'h0000FF6;
   localparam logic [CLUSTER_W-1:0] TOP_16 = 28'h000FFF6;
   localparam logic [CLUSTER_W-1:0] TOP_32 = 28'hFFFFFF6;
   localparam logic [CLUSTER_W-1:0] EOC_12 = 28'h0000FF8;
   localparam logic [CLUSTER_W-1:0] EOC_16 = 28'h000FFF8;
   localparam logic [CLUSTER_W-1:0] EOC_32 = 28'hFFFFFF8;
   localparam logic [CLUSTER_W-1:0] BAD_12 = 28'h0000FF7;
   localparam logic [CLUSTER_W-1:0] BAD_16 = 28'h000FFF7;
   localparam logic [CLUSTER_W-1:0] BAD_32 = 28'hFFFFFF7;

   typedef struct packed {
      logic [SECTOR_W-1:0] extent_start;
      logic [LENGTH_W-1:0] extent_sectors;
      logic                extent_valid;
      logic                chain_end;
      cause_type           end_cause;
   } extent_rec_type;

   logic clock;
   logic reset;

   fceb_req_if req_bus ();
   fceb_rsp_if rsp_bus ();
   fceb_csr_if csr_bus ();

   fat_chain_extent_builder_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Shadow copy of the configuration registers, updated on each write transfer.
   logic [FAT_TYPE_W-1:0] cfg_fat;
   logic [SPC_W-1:0]      cfg_spc;
   logic [SECTOR_W-1:0]   cfg_first;

   // Shadow copy of the run being built and of the idle flag.
   logic [SECTOR_W-1:0] trail_start;
   logic [LENGTH_W-1:0] trail_len;
   logic                chain_idle;

   // Extents the block still owes us, oldest first.
   extent_rec_type due_extents[$];

   int error_count = 0;
   int live_items = 0;
   int req_calm = 0;
   int rsp_calm = 0;
   int rsp_stall = 0;
   int idle_cycles = 0;

   function automatic logic is_end_mark(input logic [CLUSTER_W-1:0] c);
      case (cfg_fat)
         FAT_12:  return c >= EOC_12;
         FAT_16:  return c >= EOC_16;
         FAT_32:  return c >= EOC_32;
         default: return 1'b1;
      endcase
   endfunction

   function automatic logic is_bad_mark(input logic [CLUSTER_W-1:0] c);
      case (cfg_fat)
         FAT_12:  return c == BAD_12;
         FAT_16:  return c == BAD_16;
         FAT_32:  return c == BAD_32;
         default: return 1'b0;
      endcase
   endfunction

   // Folds one accepted cluster into the shadow run. Returns 1 when the
   // cluster closes an extent or the chain, with the result in ext.
   function automatic bit fold_cluster(input logic [CLUSTER_W-1:0] c, input logic first,
                                       output extent_rec_type ext);
      cause_type           why;
      logic [SECTOR_W-1:0] sector;
      logic [LENGTH_W:0]   run_end;
      logic [LENGTH_W:0]   grown;
      bit                  emit;
      ext = '0;
      if (first) begin
         trail_start = '0;
         trail_len = '0;
         chain_idle = 1'b0;
      end
      if (chain_idle)
         return 1'b0;

      // The end marker test wins over the other two, and below two wins over bad.
      why = CAUSE_NONE;
      if (is_end_mark(c))
         why = CAUSE_END_MARK;
      else if (c < CLUSTER_BASE)
         why = CAUSE_BELOW_TWO;
      else if (is_bad_mark(c))
         why = CAUSE_BAD;

      if (why != CAUSE_NONE) begin
         chain_idle = 1'b1;
         ext.chain_end = 1'b1;
         ext.end_cause = why;
         if (trail_len != 0) begin
            ext.extent_start = trail_start;
            ext.extent_sectors = trail_len;
            ext.extent_valid = 1'b1;
         end
         trail_start = '0;
         trail_len = '0;
         return 1'b1;
      end

      // The sector wraps at 32 bits, but the end of the run does not.
      sector = cfg_first + ({4'd0, c} - {4'd0, CLUSTER_BASE}) * {24'd0, cfg_spc};
      run_end = {9'd0, trail_start} + {1'b0, trail_len};
      if ({9'd0, sector} == run_end) begin
         grown = {1'b0, trail_len} + {33'd0, cfg_spc};
         trail_len = grown[LENGTH_W] ? '1 : grown[LENGTH_W-1:0];
         return 1'b0;
      end

      emit = trail_len != 0;
      if (emit) begin
         ext.extent_start = trail_start;
         ext.extent_sectors = trail_len;
         ext.extent_valid = 1'b1;
         ext.end_cause = CAUSE_NONE;
      end
      trail_start = sector;
      trail_len = {32'd0, cfg_spc};
      return emit;
   endfunction

   // Mostly no gap, some short ones, a few long ones, and now and then a
   // calm stretch with no gaps at all.
   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void check_field(input string what, input logic [LENGTH_W-1:0] want,
                                       input logic [LENGTH_W-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
      end
   endfunction

   // Every task below is entered at a falling edge with nothing yet driven in
   // that time step, and returns at a falling edge in the same condition.
   // The request valid is left high after a transfer so that back-to-back
   // clusters need only one assignment per step; hold_req lowers it.
   task automatic hold_req();
      req_bus.valid <= 1'b0;
   endtask

   task automatic send_cluster(input logic [CLUSTER_W-1:0] c, input logic first);
      int             gap;
      bit             ignored;
      extent_rec_type ext;
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cluster <= c;
      req_bus.new_chain <= first;
      do
         @(posedge clock);
      while (req_bus.ready !== 1'b1);
      ignored = chain_idle && !first;
      if (!ignored)
         live_items++;
      if (fold_cluster(c, first, ext))
         due_extents.insert(due_extents.size(), ext);
      @(negedge clock);
   endtask

   // Stops sending and waits until the block has nothing left in flight.
   task automatic wait_drained();
      hold_req();
      while (due_extents.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data <= data;
      do
         @(posedge clock);
      while (csr_bus.ready !== 1'b1);
      if (index == CSR_FAT_TYPE)
         cfg_fat = data[FAT_TYPE_W-1:0];
      else if (index == CSR_CLUSTER_SECTORS)
         cfg_spc = data[SPC_W-1:0];
      else if (index == CSR_FIRST_DATA_SECTOR)
         cfg_first = data;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   // The unused upper bits of the two narrow registers carry random junk,
   // which the block must drop.
   task automatic configure(input logic [FAT_TYPE_W-1:0] fat, input logic [SPC_W-1:0] spc,
                            input logic [SECTOR_W-1:0] first_sector);
      logic [CSR_DATA_W-1:0] junk;
      wait_drained();
      junk = $urandom();
      csr_write(CSR_FAT_TYPE, {junk[CSR_DATA_W-1:FAT_TYPE_W], fat});
      junk = $urandom();
      csr_write(CSR_CLUSTER_SECTORS, {junk[CSR_DATA_W-1:SPC_W], spc});
      csr_write(CSR_FIRST_DATA_SECTOR, first_sector);
   endtask

   function automatic logic [CLUSTER_W-1:0] top_cluster();
      case (cfg_fat)
         FAT_12:  return TOP_12;
         FAT_16:  return TOP_16;
         default: return TOP_32;
      endcase
   endfunction

   function automatic logic [CLUSTER_W-1:0] end_value();
      logic [CLUSTER_W-1:0] thr;
      case (cfg_fat)
         FAT_12:  thr = EOC_12;
         FAT_16:  thr = EOC_16;
         default: thr = EOC_32;
      endcase
      if ($urandom_range(0, 1) == 0)
         return thr;
      return CLUSTER_W'($urandom_range(28'hFFFFFFF, thr));
   endfunction

   function automatic logic [CLUSTER_W-1:0] bad_value();
      case (cfg_fat)
         FAT_12:  return BAD_12;
         FAT_16:  return BAD_16;
         default: return BAD_32;
      endcase
   endfunction

   // Small clusters keep sectors low; the rest span the whole legal range.
   function automatic logic [CLUSTER_W-1:0] any_cluster(input logic [CLUSTER_W-1:0] top);
      if ($urandom_range(0, 4) == 0)
         return CLUSTER_W'($urandom_range(2, 40));
      return CLUSTER_W'($urandom_range(2, top));
   endfunction

   // One chain: a first cluster, a run of mostly consecutive clusters with
   // breaks, repeats and steps back, then one of the terminators. Some chains
   // are abandoned by the next new_chain, some end in a noise item, and some
   // are followed by items that the idle block must drop.
   task automatic send_chain();
      logic [CLUSTER_W-1:0] c;
      logic [CLUSTER_W-1:0] top;
      int                   len;
      int                   r;
      top = top_cluster();
      c = any_cluster(top);
      send_cluster(c, 1'b1);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      repeat (len) begin
         r = $urandom_range(0, 99);
         if (r < 70 && c < top)
            c = c + 1'b1;
         else if (r < 80)
            c = any_cluster(top);
         else if (r < 88)
            c = c;
         else if (r < 94 && c > CLUSTER_BASE)
            c = c - 1'b1;
         else
            c = (c <= top - 2'd2) ? c + 2'd2 : CLUSTER_BASE;
         send_cluster(c, 1'b0);
      end
      r = $urandom_range(0, 99);
      if (r < 30)
         send_cluster(end_value(), 1'b0);
      else if (r < 50)
         send_cluster(CLUSTER_W'($urandom_range(0, 1)), 1'b0);
      else if (r < 70)
         send_cluster(bad_value(), 1'b0);
      else if (r >= 85)
         send_cluster(CLUSTER_W'($urandom()), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 6) == 0)
         repeat ($urandom_range(1, 3)) send_cluster(CLUSTER_W'($urandom()), 1'b0);
      if ($urandom_range(0, 49) == 0)
         wait_drained();
   endtask

   task automatic run_phase(input logic [FAT_TYPE_W-1:0] fat, input logic [SPC_W-1:0] spc,
                            input logic [SECTOR_W-1:0] first_sector, input int count);
      int base;
      configure(fat, spc, first_sector);
      base = live_items;
      while (live_items - base < count)
         send_chain();
   endtask

   // Runs merge and split at reset values (FAT32, one sector per cluster, data
   // at sector 0). Cluster 2 maps to sector 0, which joins the empty run at 0.
   task automatic test_merge_and_split();
      send_cluster(28'd2, 1'b1);
      send_cluster(28'd3, 1'b0);
      send_cluster(28'd10, 1'b0);
      send_cluster(EOC_32, 1'b0);
      // The chain is over, so this one must be dropped without a result.
      send_cluster(28'd5, 1'b0);
   endtask

   // Each way of ending a chain without a pending run, a cluster below two also
   // with one, and the largest cluster that is still a normal one.
   task automatic test_end_causes();
      send_cluster(28'd1, 1'b1);
      send_cluster(BAD_32, 1'b1);
      send_cluster(28'hFFFFFFF, 1'b1);
      send_cluster(TOP_32, 1'b1);
      send_cluster(28'd0, 1'b0);
   endtask

   // FAT12 markers with 128 sectors per cluster and the last data sector,
   // so the sector computation wraps.
   task automatic test_fat12_wrap();
      configure(FAT_12, 8'd128, 32'hFFFFFFFF);
      send_cluster(TOP_12, 1'b1);
      send_cluster(BAD_12, 1'b0);
      send_cluster(EOC_12, 1'b1);
   endtask

   // With zero sectors per cluster the run never grows, so the chain ends empty.
   task automatic test_zero_sectors();
      configure(FAT_16, 8'd0, 32'd0);
      send_cluster(TOP_16, 1'b1);
      send_cluster(28'd7, 1'b0);
      send_cluster(EOC_16, 1'b0);
      send_cluster(BAD_16, 1'b1);
   endtask

   // The undefined FAT type ends a chain on any cluster and knows no bad marker.
   task automatic test_undefined_fat();
      configure(FAT_UNDEFINED, 8'd1, 32'd0);
      send_cluster(28'd2, 1'b1);
      send_cluster(BAD_32, 1'b1);
   endtask

   // Random chains over a spread of settings, the extremes among them.
   task automatic test_random_chains();
      run_phase(FAT_32, 8'd1, 32'd0, 160);
      run_phase(FAT_12, 8'd128, $urandom(), 160);
      run_phase(FAT_16, 8'd8, 32'hFFFFFFFF, 160);
      run_phase(FAT_32, 8'd255, 32'hFFFF0000, 160);
      run_phase(FAT_32, SPC_W'($urandom_range(1, 128)), $urandom(), 160);
      run_phase(FAT_12, 8'd1, $urandom(), 140);
      run_phase(FAT_16, 8'd0, $urandom(), 60);
      run_phase(FAT_UNDEFINED, SPC_W'($urandom_range(0, 255)), $urandom(), 40);
      run_phase(FAT_16, SPC_W'($urandom_range(0, 255)), $urandom(), 140);
      run_phase(FAT_32, SPC_W'($urandom_range(1, 4)), $urandom(), 120);
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cluster = '0;
      req_bus.new_chain = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_FAT_TYPE;
      csr_bus.data = '0;
      cfg_fat = FAT_TYPE_RESET;
      cfg_spc = SPC_RESET;
      cfg_first = '0;
      trail_start = '0;
      trail_len = '0;
      chain_idle = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_merge_and_split();
      test_end_causes();
      test_fat12_wrap();
      test_zero_sectors();
      test_undefined_fat();
      test_random_chains();

      // Let the last results come out, then give a late extra result time to show.
      wait_drained();
      repeat (16) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // The response side stalls on its own schedule, independent of the sender.
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_bus.ready <= 1'b1;
         rsp_stall = pick_gap(rsp_calm);
      end
   end

   // Every result transfer is matched against the oldest extent still owed.
   always @(posedge clock) begin
      extent_rec_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (due_extents.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, got start 0x%0h sectors 0x%0h valid %0b end %0b cause %0d",
                     $time, rsp_bus.extent_start, rsp_bus.extent_sectors,
                     rsp_bus.extent_valid, rsp_bus.chain_end, rsp_bus.end_cause);
         end else begin
            want = due_extents.pop_front();
            check_field("extent_start", {8'd0, want.extent_start}, {8'd0, rsp_bus.extent_start});
            check_field("extent_sectors", want.extent_sectors, rsp_bus.extent_sectors);
            check_field("extent_valid", {39'd0, want.extent_valid}, {39'd0, rsp_bus.extent_valid});
            check_field("chain_end", {39'd0, want.chain_end}, {39'd0, rsp_bus.chain_end});
            check_field("end_cause", {38'd0, want.end_cause}, {38'd0, rsp_bus.end_cause});
         end
      end
   end

   // The run is declared hung when no channel completes a transfer for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                  $time, STALL_LIMIT, due_extents.size());
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
